[rtl/core/binary_lifting_lca_defines.svh]
// ----------------------------------------------------------------------------
// binary_lifting_lca assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BINARY_LIFTING_LCA_DEFINES_SVH
`define BINARY_LIFTING_LCA_DEFINES_SVH

`ifndef SYNTH
`define BLCA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("binary_lifting_lca: check failed");
`define BLCA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("binary_lifting_lca: check failed");
`else
`define BLCA_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BLCA_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

[rtl/core/blca_pkg.sv]
// ----------------------------------------------------------------------------
// blca_pkg
// shared widths, table addressing and table port bundles
// ----------------------------------------------------------------------------
package blca_pkg;

    localparam int NODE_W      = 10;
    localparam int NODE_COUNT  = 1 << NODE_W;
    localparam int LEVEL_COUNT = 10;
    localparam int LEVEL_W     = $clog2(LEVEL_COUNT + 1);
    localparam int DEPTH_W     = 10;
    localparam int ANC_DEPTH   = NODE_COUNT * LEVEL_COUNT;
    localparam int ANC_AW      = $clog2(ANC_DEPTH);
    localparam int LIFT_W      = 17;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    typedef struct packed {
        logic               dep_we;
        logic [NODE_W-1:0]  dep_waddr;
        logic [DEPTH_W-1:0] dep_wdata;
        logic [NODE_W-1:0]  dep_raddr_a;
        logic [NODE_W-1:0]  dep_raddr_b;
        logic               anc_we;
        logic [NODE_W-1:0]  anc_wnode;
        logic [LEVEL_W-1:0] anc_wlevel;
        logic [NODE_W-1:0]  anc_wdata;
        logic [NODE_W-1:0]  anc_rnode_a;
        logic [LEVEL_W-1:0] anc_rlevel_a;
        logic [NODE_W-1:0]  anc_rnode_b;
        logic [LEVEL_W-1:0] anc_rlevel_b;
    } store_req_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] dep_rd_a;
        logic [DEPTH_W-1:0] dep_rd_b;
        logic [NODE_W-1:0]  anc_rd_a;
        logic [NODE_W-1:0]  anc_rd_b;
    } store_rsp_t;

    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                   input logic [LEVEL_W-1:0] level);
        return ANC_AW'(ANC_AW'(node) * ANC_AW'(LEVEL_COUNT) + ANC_AW'(level));
    endfunction

    function automatic logic [DEPTH_W-1:0] depth_inc(input logic [DEPTH_W-1:0] d);
        return (d == DEPTH_MAX) ? DEPTH_MAX : d + DEPTH_W'(1);
    endfunction

endpackage

[rtl/core/blca_store.sv]
// ----------------------------------------------------------------------------
// blca_store
// depth table and ancestor table, one write and two registered reads each
// ----------------------------------------------------------------------------
module blca_store (
    input  logic                 aclk,
    input  blca_pkg::store_req_t req,
    output blca_pkg::store_rsp_t rsp
);

    logic [blca_pkg::DEPTH_W-1:0] dep_mem [blca_pkg::NODE_COUNT];
    logic [blca_pkg::NODE_W-1:0]  anc_mem [blca_pkg::ANC_DEPTH];

    logic [blca_pkg::DEPTH_W-1:0] dep_rd_a_reg;
    logic [blca_pkg::DEPTH_W-1:0] dep_rd_b_reg;
    logic [blca_pkg::NODE_W-1:0]  anc_rd_a_reg;
    logic [blca_pkg::NODE_W-1:0]  anc_rd_b_reg;

    always_ff @(posedge aclk) begin
        if (req.dep_we) begin
            dep_mem[req.dep_waddr] <= req.dep_wdata;
        end
        dep_rd_a_reg <= dep_mem[req.dep_raddr_a];
        dep_rd_b_reg <= dep_mem[req.dep_raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (req.anc_we) begin
            anc_mem[blca_pkg::anc_addr(req.anc_wnode, req.anc_wlevel)] <= req.anc_wdata;
        end
        anc_rd_a_reg <= anc_mem[blca_pkg::anc_addr(req.anc_rnode_a, req.anc_rlevel_a)];
        anc_rd_b_reg <= anc_mem[blca_pkg::anc_addr(req.anc_rnode_b, req.anc_rlevel_b)];
    end

    assign rsp.dep_rd_a = dep_rd_a_reg;
    assign rsp.dep_rd_b = dep_rd_b_reg;
    assign rsp.anc_rd_a = anc_rd_a_reg;
    assign rsp.anc_rd_b = anc_rd_b_reg;

endmodule

[rtl/core/binary_lifting_lca.sv]
// ----------------------------------------------------------------------------
// binary_lifting_lca
// lowest common ancestor engine for a rooted tree using binary lifting
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one transaction per command; tuser selects insert (0) or
//   query (1), tdata carries node_a and node_b. inserts must name the
//   parent before the child; the root index comes from the cfg channel.
//   m_ channel: one transaction per command; zero for an insert, the
//   lowest common ancestor for a query.
//   the engine steps through the ancestor table one lift level at a time,
//   for an insert and for a query; the next command can be accepted in the
//   cycle after a result enters the output register.
//   s_tready is high only between commands; a finished result waits in the
//   output register, so the next command can be taken while the receiver
//   stalls, and its result waits until the register is free.
//   aresetn (synchronous) clears the sequencer, the output valid and the
//   root index to zero; table contents are undefined until written.
//   cfg writes are taken at any time but belong between commands.
// ----------------------------------------------------------------------------
`include "binary_lifting_lca_defines.svh"

module binary_lifting_lca (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [blca_pkg::NODE_W-1:0]      cfg_data,      // root_node
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [blca_pkg::S_TDATA_W-1:0]   s_tdata,       // node_a, node_b, zero pad
    input  logic [0:0]                       s_tuser,       // operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [blca_pkg::M_TDATA_W-1:0]   m_tdata        // answer_node, zero pad
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INS_DRD = 4'd1;
    localparam logic [3:0] ST_INS_DWR = 4'd2;
    localparam logic [3:0] ST_INS_RD  = 4'd3;
    localparam logic [3:0] ST_INS_WR  = 4'd4;
    localparam logic [3:0] ST_Q_RD    = 4'd5;
    localparam logic [3:0] ST_Q_DEP   = 4'd6;
    localparam logic [3:0] ST_Q_LRD   = 4'd7;
    localparam logic [3:0] ST_Q_LWR   = 4'd8;
    localparam logic [3:0] ST_Q_EQ    = 4'd9;
    localparam logic [3:0] ST_Q_JRD   = 4'd10;
    localparam logic [3:0] ST_Q_JCMP  = 4'd11;
    localparam logic [3:0] ST_Q_FRD   = 4'd12;
    localparam logic [3:0] ST_Q_FWR   = 4'd13;
    localparam logic [3:0] ST_RESULT  = 4'd14;

    localparam int NW = blca_pkg::NODE_W;
    localparam int LW = blca_pkg::LEVEL_W;
    localparam int DW = blca_pkg::DEPTH_W;
    localparam logic [LW-1:0] LV_TOP = LW'(blca_pkg::LEVEL_COUNT - 1);
    localparam logic [LW-1:0] LV_END = LW'(blca_pkg::LEVEL_COUNT);

    logic [3:0]    state_reg, state_next;
    logic          op_reg, op_next;
    logic [NW-1:0] a_reg, a_next;
    logic [NW-1:0] b_reg, b_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic [DW-1:0] diff_reg, diff_next;
    logic [NW-1:0] result_reg, result_next;
    logic [NW-1:0] root_reg;
    logic          out_valid_reg, out_valid_next;
    logic [NW-1:0] out_data_reg, out_data_next;

    blca_pkg::store_req_t req;
    blca_pkg::store_rsp_t rsp;

    logic [blca_pkg::LIFT_W-1:0] lift_step;
    logic                        lift_take;
    logic                        is_root;
    logic [DW-1:0]               ins_depth;
    logic [NW-1:0]               ins_anc0;
    logic                        lift_st;

    blca_store u_store (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = blca_pkg::M_TDATA_W'(out_data_reg);

    assign lift_step = blca_pkg::LIFT_W'(1) << lv_reg;
    assign lift_take = blca_pkg::LIFT_W'(diff_reg) >= lift_step;
    assign is_root   = (a_reg == root_reg);
    assign ins_depth = is_root ? '0 : blca_pkg::depth_inc(rsp.dep_rd_b);
    assign ins_anc0  = is_root ? a_reg : b_reg;
    assign lift_st   = (state_reg == ST_Q_LRD) || (state_reg == ST_Q_LWR) ||
                       (state_reg == ST_Q_JRD) || (state_reg == ST_Q_JCMP);

    always_comb begin
        req              = '0;
        req.dep_waddr    = a_reg;
        req.dep_wdata    = ins_depth;
        req.dep_raddr_a  = a_reg;
        req.dep_raddr_b  = b_reg;
        req.anc_wnode    = a_reg;
        req.anc_wlevel   = lv_reg;
        req.anc_wdata    = rsp.anc_rd_a;
        req.anc_rnode_a  = a_reg;
        req.anc_rlevel_a = lv_reg;
        req.anc_rnode_b  = b_reg;
        req.anc_rlevel_b = lv_reg;
        unique case (state_reg)
            ST_INS_DWR: begin
                req.dep_we     = 1'b1;
                req.anc_we     = 1'b1;
                req.anc_wlevel = '0;
                req.anc_wdata  = ins_anc0;
            end
            ST_INS_RD: begin
                req.anc_rnode_a  = cur_reg;
                req.anc_rlevel_a = lv_reg - LW'(1);
            end
            ST_INS_WR: begin
                req.anc_we = 1'b1;
            end
            ST_Q_LRD: begin
                req.anc_rnode_a = b_reg;
            end
            ST_Q_FRD: begin
                req.anc_rlevel_a = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cur_next       = cur_reg;
        lv_next        = lv_reg;
        diff_next      = diff_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser[0];
                    a_next     = s_tdata[NW-1:0];
                    b_next     = s_tdata[2*NW-1:NW];
                    state_next = s_tuser[0] ? ST_Q_RD : ST_INS_DRD;
                end
            end
            ST_INS_DRD: begin
                state_next = ST_INS_DWR;
            end
            ST_INS_DWR: begin
                cur_next   = ins_anc0;
                lv_next    = LW'(1);
                state_next = ST_INS_RD;
            end
            ST_INS_RD: begin
                if (lv_reg == LV_END) begin
                    result_next = '0;
                    state_next  = ST_RESULT;
                end else begin
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                cur_next   = rsp.anc_rd_a;
                lv_next    = lv_reg + LW'(1);
                state_next = ST_INS_RD;
            end
            ST_Q_RD: begin
                if (a_reg == b_reg) begin
                    result_next = a_reg;
                    state_next  = ST_RESULT;
                end else begin
                    state_next = ST_Q_DEP;
                end
            end
            ST_Q_DEP: begin
                if (rsp.dep_rd_a > rsp.dep_rd_b) begin
                    a_next    = b_reg;
                    b_next    = a_reg;
                    diff_next = rsp.dep_rd_a - rsp.dep_rd_b;
                end else begin
                    diff_next = rsp.dep_rd_b - rsp.dep_rd_a;
                end
                lv_next    = LV_TOP;
                state_next = ST_Q_LRD;
            end
            ST_Q_LRD: begin
                if (lift_take) begin
                    state_next = ST_Q_LWR;
                end else if (lv_reg == '0) begin
                    state_next = ST_Q_EQ;
                end else begin
                    lv_next = lv_reg - LW'(1);
                end
            end
            ST_Q_LWR: begin
                b_next    = rsp.anc_rd_a;
                diff_next = diff_reg - DW'(lift_step);
                if (lv_reg == '0) begin
                    state_next = ST_Q_EQ;
                end else begin
                    lv_next    = lv_reg - LW'(1);
                    state_next = ST_Q_LRD;
                end
            end
            ST_Q_EQ: begin
                if (a_reg == b_reg) begin
                    result_next = a_reg;
                    state_next  = ST_RESULT;
                end else begin
                    lv_next    = LV_TOP;
                    state_next = ST_Q_JRD;
                end
            end
            ST_Q_JRD: begin
                state_next = ST_Q_JCMP;
            end
            ST_Q_JCMP: begin
                if (rsp.anc_rd_a != rsp.anc_rd_b) begin
                    a_next = rsp.anc_rd_a;
                    b_next = rsp.anc_rd_b;
                end
                if (lv_reg == '0) begin
                    state_next = ST_Q_FRD;
                end else begin
                    lv_next    = lv_reg - LW'(1);
                    state_next = ST_Q_JRD;
                end
            end
            ST_Q_FRD: begin
                state_next = ST_Q_FWR;
            end
            ST_Q_FWR: begin
                result_next = rsp.anc_rd_a;
                state_next  = ST_RESULT;
            end
            ST_RESULT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            root_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                root_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        cur_reg      <= cur_next;
        lv_reg       <= lv_next;
        diff_reg     <= diff_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    `BLCA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, state_reg != ST_IDLE)
    `BLCA_ASSERT_IMP(a_lift_level_range, aclk, aresetn, lift_st, lv_reg <= LV_TOP)
    `BLCA_ASSERT_IMP(a_insert_zero, aclk, aresetn, (state_reg == ST_RESULT) && !op_reg, result_reg == '0)
    `BLCA_ASSERT_IMP(a_lift_no_underflow, aclk, aresetn, state_reg == ST_Q_LWR, lift_take)

endmodule

[bench/tb_binary_lifting_lca.sv]
// ----------------------------------------------------------------------------
// tb_binary_lifting_lca
// drives insert and query transactions into the lowest common ancestor engine,
// keeps its own depth and jump tables to predict each answer, and checks
// every result transaction in order under random stalls on both channels
// ----------------------------------------------------------------------------
module tb_binary_lifting_lca;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PAD_W       = blca_pkg::S_TDATA_W - 2 * blca_pkg::NODE_W;

    typedef logic [blca_pkg::NODE_W-1:0]  node_t;
    typedef logic [blca_pkg::DEPTH_W-1:0] depth_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } tree_op_t;

    typedef struct packed {
        tree_op_t op;
        node_t    node_a;
        node_t    node_b;
    } tree_cmd_t;

    typedef struct packed {
        tree_cmd_t                        cmd;
        logic [blca_pkg::M_TDATA_W-1:0]   tdata;
    } answer_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [blca_pkg::NODE_W-1:0]      cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [blca_pkg::S_TDATA_W-1:0]   s_tdata = '0;       // node_a, node_b, zero pad
    logic [0:0]                       s_tuser = '0;       // operation
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [blca_pkg::M_TDATA_W-1:0]   m_tdata;            // answer_node, zero pad

    // predictor state
    node_t      root_q = '0;
    depth_t     depth_q [blca_pkg::NODE_COUNT];
    node_t      jump_q  [blca_pkg::NODE_COUNT][blca_pkg::LEVEL_COUNT];

    // stimulus bookkeeping
    tree_cmd_t  cmd_q[$];
    answer_t    answer_q[$];
    node_t      known_q[$];
    bit         seen_q [blca_pkg::NODE_COUNT];
    node_t      gen_root = '0;
    tree_cmd_t  cur_cmd;
    answer_t    head_answer;
    int         idle_pct = 8;
    int         err_cnt = 0;
    int         cycle_cnt = 0;

    binary_lifting_lca u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic void record_insert(input node_t n, input node_t p);
        int lv;
        if (n == root_q) begin
            depth_q[n] = '0;
            for (lv = 0; lv < blca_pkg::LEVEL_COUNT; lv++) jump_q[n][lv] = n;
        end else begin
            depth_q[n] = (depth_q[p] == blca_pkg::DEPTH_MAX) ? blca_pkg::DEPTH_MAX
                                                             : depth_q[p] + depth_t'(1);
            jump_q[n][0] = p;
            for (lv = 1; lv < blca_pkg::LEVEL_COUNT; lv++) begin
                jump_q[n][lv] = jump_q[jump_q[n][lv-1]][lv-1];
            end
        end
    endfunction

    function automatic node_t lift_lca(input node_t a, input node_t b);
        node_t lo;
        node_t hi;
        int    gap;
        int    lv;
        if (a == b) return a;
        lo = a;
        hi = b;
        if (depth_q[a] > depth_q[b]) begin
            lo = b;
            hi = a;
        end
        gap = int'(depth_q[hi]) - int'(depth_q[lo]);
        for (lv = blca_pkg::LEVEL_COUNT - 1; lv >= 0; lv--) begin
            if (gap >= (1 << lv)) begin
                hi = jump_q[hi][lv];
                gap -= (1 << lv);
            end
        end
        if (lo == hi) return lo;
        for (lv = blca_pkg::LEVEL_COUNT - 1; lv >= 0; lv--) begin
            if (jump_q[lo][lv] != jump_q[hi][lv]) begin
                lo = jump_q[lo][lv];
                hi = jump_q[hi][lv];
            end
        end
        return jump_q[lo][0];
    endfunction

    function automatic void predict_cmd(input tree_cmd_t c);
        answer_t e;
        e.cmd = c;
        if (c.op == OP_INSERT) begin
            record_insert(c.node_a, c.node_b);
            e.tdata = '0;
        end else begin
            e.tdata = blca_pkg::M_TDATA_W'(lift_lca(c.node_a, c.node_b));
        end
        answer_q = {answer_q, e};
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_cmd(cur_cmd);
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {PAD_W'(0), cur_cmd.node_b, cur_cmd.node_a};
                    s_tuser  <= cur_cmd.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with none expected, actual %0d", $time, m_tdata);
                end else begin
                    head_answer = answer_q.pop_front();
                    if (m_tdata !== head_answer.tdata) begin
                        err_cnt++;
                        $display("%0t: op %s a %0d b %0d, expected %0d, actual %0d", $time,
                                 head_answer.cmd.op.name(), head_answer.cmd.node_a,
                                 head_answer.cmd.node_b, head_answer.tdata, m_tdata);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic node_t pick_known();
        return known_q[$urandom_range(known_q.size() - 1)];
    endfunction

    function automatic void push_insert(input node_t n, input node_t p);
        tree_cmd_t c;
        c = '{OP_INSERT, n, p};
        cmd_q = {cmd_q, c};
        if (!seen_q[n]) begin
            seen_q[n] = 1'b1;
            known_q = {known_q, n};
        end
    endfunction

    function automatic void push_query(input node_t a, input node_t b);
        tree_cmd_t c;
        c = '{OP_QUERY, a, b};
        cmd_q = {cmd_q, c};
    endfunction

    task automatic drain();
        while (cmd_q.size() != 0 || s_tvalid || answer_q.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic set_root(input node_t v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        root_q = v;
        gen_root = v;
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_phase(input int count);
        int r;
        node_t x;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 3) begin
                push_insert(gen_root, node_t'($urandom_range(blca_pkg::NODE_COUNT - 1)));
            end else if (r < 45) begin
                push_insert(node_t'($urandom_range(blca_pkg::NODE_COUNT - 1)), pick_known());
            end else if (r < 50) begin
                x = pick_known();
                push_query(x, x);
            end else begin
                push_query(pick_known(), pick_known());
            end
        end
    endtask

    initial begin
        int    k;
        node_t n;
        node_t tip;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // hand-picked tree under the reset root
        idle_pct = 8;
        push_insert(10'd0, 10'd1023);
        push_insert(10'd1023, 10'd0);
        push_insert(10'd512, 10'd1023);
        push_insert(10'd341, 10'd512);
        push_insert(10'd682, 10'd0);
        push_insert(10'd5, 10'd341);
        push_query(10'd0, 10'd0);
        push_query(10'd1023, 10'd1023);
        push_query(10'd512, 10'd682);
        push_query(10'd341, 10'd1023);
        push_query(10'd1023, 10'd341);
        push_query(10'd341, 10'd682);
        push_query(10'd5, 10'd512);
        push_query(10'd0, 10'd5);
        push_insert(10'd682, 10'd341);
        push_query(10'd682, 10'd5);
        push_insert(10'd5, 10'd5);
        push_query(10'd5, 10'd0);
        push_insert(10'd0, 10'd682);
        push_query(10'd682, 10'd0);
        drain();

        // one long chain down to depth saturation under the top root
        set_root(10'd1023);
        idle_pct = 0;
        push_insert(10'd1023, node_t'($urandom_range(blca_pkg::NODE_COUNT - 1)));
        tip = 10'd1023;
        for (k = 0; k < 1030; k++) begin
            do n = node_t'($urandom_range(blca_pkg::NODE_COUNT - 1)); while (n == gen_root);
            push_insert(n, tip);
            tip = n;
            if ($urandom_range(99) < 5) push_query(pick_known(), pick_known());
            if ($urandom_range(99) < 2) push_query(tip, pick_known());
            if (k == 400) begin
                drain();
                idle_pct = 8;
            end
        end
        push_query(tip, gen_root);
        push_query(gen_root, tip);
        drain();

        set_root(node_t'($urandom_range(1, blca_pkg::NODE_COUNT - 2)));
        push_insert(gen_root, node_t'($urandom_range(blca_pkg::NODE_COUNT - 1)));
        random_phase(80);
        drain();

        set_root(10'd0);
        push_insert(gen_root, node_t'($urandom_range(blca_pkg::NODE_COUNT - 1)));
        random_phase(60);
        drain();
        repeat (60) @(posedge aclk);

        if (err_cnt == 0 && answer_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
